### rtl/ltq_pkg.sv
package ltq_pkg;

	// widened corner position: start/end plus a half-width offset fits in 35 bits
	localparam int PW = 35;
	localparam int QBITS = 31;
	localparam int SQ_STEPS = 32;
	localparam int DIV_STEPS = 31;
	localparam int QDEPTH = 4;
	localparam int QPTR = 2;
	localparam int QCNT = 3;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sz;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic signed [31:0] ez;
		logic [31:0] color;
		logic neg_x;
		logic neg_y;
		logic degen;
	} seg_t;

	typedef struct packed {
		logic [3:0][31:0] px;
		logic [3:0][31:0] py;
		logic [31:0] sz;
		logic [31:0] ez;
		logic [31:0] color;
		logic [31:0] min_x;
		logic [31:0] min_y;
		logic [31:0] max_x;
		logic [31:0] max_y;
		logic degen;
	} quad_t;

endpackage

### rtl/ltq_front.sv
module ltq_front import ltq_pkg::*; #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	input  logic signed [31:0] end_z,
	input  logic [30:0] line_width,
	input  logic [31:0] line_color,
	input  logic q_full,
	output logic q_wr,
	output quad_t q_data
);

	localparam longint SAT_HI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
	localparam longint SAT_LO = -SAT_HI - 64'sd1;
	localparam logic [63:0] EPS2 =
		((64'd1 << (2 * FRAC_BITS)) + 64'd999999999999) / 64'd1000000000000;

	function automatic logic signed [PW-1:0] sat(input logic signed [PW-1:0] v);
		longint vv;
		vv = longint'(v);
		if (vv > SAT_HI) return PW'(SAT_HI);
		if (vv < SAT_LO) return PW'(SAT_LO);
		return v;
	endfunction

	function automatic logic signed [PW-1:0] smin(input logic signed [PW-1:0] a,
			input logic signed [PW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [PW-1:0] smax(input logic signed [PW-1:0] a,
			input logic signed [PW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	logic en;
	logic accept;

	// stage 1: differences, magnitudes, range shift
	logic signed [32:0] dx, dy, dz;
	logic [32:0] ax, ay, az, am;
	logic [1:0] shamt;
	logic v_s1;
	seg_t seg_s1;
	logic [QBITS-1:0] qx_s1, qy_s1, qz_s1;
	logic [30:0] w_s1;
	logic szero_s1;

	// stage 2: squares and width products
	logic v_s2;
	seg_t seg_s2;
	logic [61:0] sqx_s2, sqy_s2, sqz_s2, pwx_s2, pwy_s2;
	logic szero_s2;
	logic [63:0] sum;

	// stage 3 and square root steps share arrays, entry 0 is stage 3
	logic sq_v_s [0:SQ_STEPS];
	logic [63:0] sq_n_s [0:SQ_STEPS];
	logic [63:0] sq_root_s [0:SQ_STEPS];
	logic [61:0] sq_pwx_s [0:SQ_STEPS];
	logic [61:0] sq_pwy_s [0:SQ_STEPS];
	seg_t sq_seg_s [0:SQ_STEPS];

	// stage 4 and divide steps, entry 0 is stage 4
	logic [63:0] len;
	logic dv_v_s [0:DIV_STEPS];
	logic [63:0] dv_rx_s [0:DIV_STEPS];
	logic [63:0] dv_ry_s [0:DIV_STEPS];
	logic [32:0] dv_den_s [0:DIV_STEPS];
	logic [QBITS-1:0] dv_qx_s [0:DIV_STEPS];
	logic [QBITS-1:0] dv_qy_s [0:DIV_STEPS];
	seg_t dv_seg_s [0:DIV_STEPS];

	// stage 5: corners
	logic signed [PW-1:0] mxs, mys, rx, ry;
	logic v_s5;
	logic signed [PW-1:0] px_s5 [0:3];
	logic signed [PW-1:0] py_s5 [0:3];
	logic signed [PW-1:0] sz_s5, ez_s5;
	logic [31:0] color_s5;
	logic degen_s5;

	// stage 6: bounds, queue record
	logic v_s6;
	quad_t rec_s6;
	logic signed [PW-1:0] bmin_x, bmin_y, bmax_x, bmax_y;

	assign en = !(v_s6 && q_full);
	assign in_stall = !en;
	assign accept = in_valid && en;
	assign q_wr = v_s6 && !q_full;
	assign q_data = rec_s6;

	always_comb begin
		dx = {end_x[31], end_x} - {start_x[31], start_x};
		dy = {end_y[31], end_y} - {start_y[31], start_y};
		dz = {end_z[31], end_z} - {start_z[31], start_z};
		ax = dx[32] ? 33'(-dx) : 33'(dx);
		ay = dy[32] ? 33'(-dy) : 33'(dy);
		az = dz[32] ? 33'(-dz) : 33'(dz);
		am = ax;
		if (ay > am) am = ay;
		if (az > am) am = az;
		if (am[32]) shamt = 2'd2;
		else if (am[31]) shamt = 2'd1;
		else shamt = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			sq_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1.sx <= start_x;
			seg_s1.sy <= start_y;
			seg_s1.sz <= start_z;
			seg_s1.ex <= end_x;
			seg_s1.ey <= end_y;
			seg_s1.ez <= end_z;
			seg_s1.color <= line_color;
			seg_s1.neg_x <= dx[32];
			seg_s1.neg_y <= dy[32];
			seg_s1.degen <= 1'b0;
			qx_s1 <= QBITS'(ax >> shamt);
			qy_s1 <= QBITS'(ay >> shamt);
			qz_s1 <= QBITS'(az >> shamt);
			w_s1 <= line_width;
			szero_s1 <= (shamt == 2'd0);

			seg_s2 <= seg_s1;
			sqx_s2 <= 62'(qx_s1) * 62'(qx_s1);
			sqy_s2 <= 62'(qy_s1) * 62'(qy_s1);
			sqz_s2 <= 62'(qz_s1) * 62'(qz_s1);
			pwx_s2 <= 62'(qx_s1) * 62'(w_s1);
			pwy_s2 <= 62'(qy_s1) * 62'(w_s1);
			szero_s2 <= szero_s1;

			sq_n_s[0] <= sum;
			sq_root_s[0] <= 64'd0;
			sq_pwx_s[0] <= pwx_s2;
			sq_pwy_s[0] <= pwy_s2;
			sq_seg_s[0] <= '{sx: seg_s2.sx, sy: seg_s2.sy, sz: seg_s2.sz,
				ex: seg_s2.ex, ey: seg_s2.ey, ez: seg_s2.ez, color: seg_s2.color,
				neg_x: seg_s2.neg_x, neg_y: seg_s2.neg_y,
				degen: szero_s2 && (sum < EPS2)};
		end
	end

	assign sum = 64'(sqx_s2) + 64'(sqy_s2) + 64'(sqz_s2);

	// one root bit per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		logic take;

		assign trial = sq_root_s[k] + BIT;
		assign take = sq_n_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_n_s[k+1] <= take ? sq_n_s[k] - trial : sq_n_s[k];
				sq_root_s[k+1] <= take ? (sq_root_s[k] >> 1) + BIT : sq_root_s[k] >> 1;
				sq_pwx_s[k+1] <= sq_pwx_s[k];
				sq_pwy_s[k+1] <= sq_pwy_s[k];
				sq_seg_s[k+1] <= sq_seg_s[k];
			end
		end
	end

	assign len = (sq_root_s[SQ_STEPS] == 64'd0) ? 64'd1 : sq_root_s[SQ_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rx_s[0] <= 64'(sq_pwx_s[SQ_STEPS]) + len;
			dv_ry_s[0] <= 64'(sq_pwy_s[SQ_STEPS]) + len;
			dv_den_s[0] <= {len[31:0], 1'b0};
			dv_qx_s[0] <= '0;
			dv_qy_s[0] <= '0;
			dv_seg_s[0] <= sq_seg_s[SQ_STEPS];
		end
	end

	// restoring divide, one quotient bit per stage for both axes
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int SH = DIV_STEPS - 1 - j;
		logic [63:0] dsh;
		logic take_x, take_y;

		assign dsh = 64'(dv_den_s[j]) << SH;
		assign take_x = dv_rx_s[j] >= dsh;
		assign take_y = dv_ry_s[j] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rx_s[j+1] <= take_x ? dv_rx_s[j] - dsh : dv_rx_s[j];
				dv_ry_s[j+1] <= take_y ? dv_ry_s[j] - dsh : dv_ry_s[j];
				dv_qx_s[j+1] <= {dv_qx_s[j][QBITS-2:0], take_x};
				dv_qy_s[j+1] <= {dv_qy_s[j][QBITS-2:0], take_y};
				dv_den_s[j+1] <= dv_den_s[j];
				dv_seg_s[j+1] <= dv_seg_s[j];
			end
		end
	end

	always_comb begin
		mxs = PW'(dv_qx_s[DIV_STEPS]);
		mys = PW'(dv_qy_s[DIV_STEPS]);
		rx = dv_seg_s[DIV_STEPS].neg_y ? mys : -mys;
		ry = dv_seg_s[DIV_STEPS].neg_x ? -mxs : mxs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv_v_s[DIV_STEPS];
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s5[0] <= sat(PW'(dv_seg_s[DIV_STEPS].sx) - rx);
			px_s5[1] <= sat(PW'(dv_seg_s[DIV_STEPS].sx) + rx);
			px_s5[2] <= sat(PW'(dv_seg_s[DIV_STEPS].ex) + rx);
			px_s5[3] <= sat(PW'(dv_seg_s[DIV_STEPS].ex) - rx);
			py_s5[0] <= sat(PW'(dv_seg_s[DIV_STEPS].sy) - ry);
			py_s5[1] <= sat(PW'(dv_seg_s[DIV_STEPS].sy) + ry);
			py_s5[2] <= sat(PW'(dv_seg_s[DIV_STEPS].ey) + ry);
			py_s5[3] <= sat(PW'(dv_seg_s[DIV_STEPS].ey) - ry);
			sz_s5 <= sat(PW'(dv_seg_s[DIV_STEPS].sz));
			ez_s5 <= sat(PW'(dv_seg_s[DIV_STEPS].ez));
			color_s5 <= dv_seg_s[DIV_STEPS].color;
			degen_s5 <= dv_seg_s[DIV_STEPS].degen;
		end
	end

	always_comb begin
		bmin_x = smin(smin(px_s5[0], px_s5[1]), smin(px_s5[2], px_s5[3]));
		bmax_x = smax(smax(px_s5[0], px_s5[1]), smax(px_s5[2], px_s5[3]));
		bmin_y = smin(smin(py_s5[0], py_s5[1]), smin(py_s5[2], py_s5[3]));
		bmax_y = smax(smax(py_s5[0], py_s5[1]), smax(py_s5[2], py_s5[3]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				rec_s6.px[c] <= px_s5[c][31:0];
				rec_s6.py[c] <= py_s5[c][31:0];
			end
			rec_s6.sz <= sz_s5[31:0];
			rec_s6.ez <= ez_s5[31:0];
			rec_s6.color <= color_s5;
			rec_s6.min_x <= bmin_x[31:0];
			rec_s6.min_y <= bmin_y[31:0];
			rec_s6.max_x <= bmax_x[31:0];
			rec_s6.max_y <= bmax_y[31:0];
			rec_s6.degen <= degen_s5;
		end
	end

endmodule

### rtl/ltq_queue.sv
module ltq_queue import ltq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  quad_t wr_data,
	output logic full,
	output logic rd_valid,
	input  logic rd_pop,
	output quad_t rd_data
);

	quad_t mem_q [0:QDEPTH-1];
	logic [QPTR-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT-1:0] count_q;
	logic do_rd;

	assign full = (count_q == QCNT'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_rd = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr && !full) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({wr && !full, do_rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/ltq_back.sv
module ltq_back import ltq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  quad_t q_data,
	output logic q_pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] corner,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic [31:0] vert_color,
	output logic signed [31:0] bound_min_x,
	output logic signed [31:0] bound_min_y,
	output logic signed [31:0] bound_max_x,
	output logic signed [31:0] bound_max_y,
	output logic degenerate,
	output logic last_of_run
);

	logic [1:0] cnt_q;
	logic out_valid_q;
	logic load, last;

	assign last = q_data.degen || (cnt_q == 2'd3);
	assign load = q_valid && (!out_valid_q || !out_stall);
	assign q_pop = load && last;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q <= last ? 2'd0 : cnt_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (q_data.degen) begin
				corner <= 2'd0;
				pos_x <= '0;
				pos_y <= '0;
				pos_z <= '0;
				vert_color <= '0;
				bound_min_x <= '0;
				bound_min_y <= '0;
				bound_max_x <= '0;
				bound_max_y <= '0;
				degenerate <= 1'b1;
				last_of_run <= 1'b1;
			end else begin
				corner <= cnt_q;
				pos_x <= q_data.px[cnt_q];
				pos_y <= q_data.py[cnt_q];
				pos_z <= cnt_q[1] ? q_data.ez : q_data.sz;
				vert_color <= q_data.color;
				bound_min_x <= q_data.min_x;
				bound_min_y <= q_data.min_y;
				bound_max_x <= q_data.max_x;
				bound_max_y <= q_data.max_y;
				degenerate <= 1'b0;
				last_of_run <= (cnt_q == 2'd3);
			end
		end
	end

	// mid-quad the head must be a normal segment
	a_cnt_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd0) |-> (q_valid && !q_data.degen))
		else $error("corner count advanced on a degenerate or missing entry");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_of_run) |-> (degenerate || corner == 2'd3))
		else $error("last_of_run on a middle corner");

	a_degen_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && degenerate) |-> (corner == 2'd0 && last_of_run))
		else $error("degenerate result not a single closing result");

	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (cnt_q == 2'd0))
		else $error("counter not rewound after pop");

endmodule

### rtl/line_to_quad_expand_core.sv
// throughput: one result per cycle while out_stall is low, four results per segment (one if degenerate)
// the output channel sets that rate; the 32-step root and 31-step divide pipelines
// and the 4-entry queue take a new segment every cycle while there is room
// reset clears all valid bits, the queue pointers and the corner counter; no clear pass
module line_to_quad_expand_core import ltq_pkg::*; #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	input  logic signed [31:0] end_z,
	input  logic [30:0] line_width,
	input  logic [31:0] line_color,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] corner,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic [31:0] vert_color,
	output logic signed [31:0] bound_min_x,
	output logic signed [31:0] bound_min_y,
	output logic signed [31:0] bound_max_x,
	output logic signed [31:0] bound_max_y,
	output logic degenerate,
	output logic last_of_run
);

	logic q_full, q_wr, q_valid, q_pop;
	quad_t q_wdata, q_rdata;

	ltq_front #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_x(start_x),
		.start_y(start_y),
		.start_z(start_z),
		.end_x(end_x),
		.end_y(end_y),
		.end_z(end_z),
		.line_width(line_width),
		.line_color(line_color),
		.q_full(q_full),
		.q_wr(q_wr),
		.q_data(q_wdata)
	);

	ltq_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(q_wr),
		.wr_data(q_wdata),
		.full(q_full),
		.rd_valid(q_valid),
		.rd_pop(q_pop),
		.rd_data(q_rdata)
	);

	ltq_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_data(q_rdata),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.corner(corner),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.vert_color(vert_color),
		.bound_min_x(bound_min_x),
		.bound_min_y(bound_min_y),
		.bound_max_x(bound_max_x),
		.bound_max_y(bound_max_y),
		.degenerate(degenerate),
		.last_of_run(last_of_run)
	);

endmodule

### tb/tb_line_to_quad_expand_core.sv
module tb_line_to_quad_expand_core;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] corner;
		logic [31:0] pos_x, pos_y, pos_z, vert_color;
		logic [31:0] bound_min_x, bound_min_y, bound_max_x, bound_max_y;
		logic degenerate, last_of_run;
	} corner_t;

	// expected corners of accepted segments, checked in order
	class quad_scoreboard;
		corner_t pending[$];
		int mismatches;
		int corners_seen;
		int degen_seen;

		static function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		static function longint unsigned int_root(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void note_segment(logic signed [31:0] sx, sy, sz, ex, ey, ez,
				logic [30:0] w, logic [31:0] color);
			longint dx, dy, dz, rx, ry, lo_x, hi_x, lo_y, hi_y;
			longint px[4], py[4];
			longint unsigned ax, ay, az, mx, qx, qy, qz, sq, root, hx, hy;
			int sh;
			corner_t c;
			dx = longint'(ex) - longint'(sx);
			dy = longint'(ey) - longint'(sy);
			dz = longint'(ez) - longint'(sz);
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			az = dz < 0 ? -dz : dz;
			mx = ax;
			if (ay > mx) mx = ay;
			if (az > mx) mx = az;
			sh = 0;
			while ((mx >> sh) >= (64'd1 << 31)) sh++;
			qx = ax >> sh;
			qy = ay >> sh;
			qz = az >> sh;
			sq = qx * qx + qy * qy + qz * qz;
			// threshold rounds up to one LSB^2 at 16 fraction bits
			if (sh == 0 && sq < 1) begin
				c = '{default: '0};
				c.degenerate = 1'b1;
				c.last_of_run = 1'b1;
				pending.push_back(c);
				return;
			end
			root = int_root(sq);
			if (root == 0) root = 1;
			hx = (qx * w + root) / (2 * root);
			hy = (qy * w + root) / (2 * root);
			rx = dy < 0 ? longint'(hy) : -longint'(hy);
			ry = dx < 0 ? -longint'(hx) : longint'(hx);
			px[0] = clamp32(sx - rx); py[0] = clamp32(sy - ry);
			px[1] = clamp32(sx + rx); py[1] = clamp32(sy + ry);
			px[2] = clamp32(ex + rx); py[2] = clamp32(ey + ry);
			px[3] = clamp32(ex - rx); py[3] = clamp32(ey - ry);
			lo_x = px[0]; hi_x = px[0]; lo_y = py[0]; hi_y = py[0];
			for (int k = 1; k < 4; k++) begin
				if (px[k] < lo_x) lo_x = px[k];
				if (px[k] > hi_x) hi_x = px[k];
				if (py[k] < lo_y) lo_y = py[k];
				if (py[k] > hi_y) hi_y = py[k];
			end
			for (int k = 0; k < 4; k++) begin
				c.corner = 2'(k);
				c.pos_x = px[k][31:0];
				c.pos_y = py[k][31:0];
				c.pos_z = k < 2 ? sz : ez;
				c.vert_color = color;
				c.bound_min_x = lo_x[31:0];
				c.bound_min_y = lo_y[31:0];
				c.bound_max_x = hi_x[31:0];
				c.bound_max_y = hi_y[31:0];
				c.degenerate = 1'b0;
				c.last_of_run = (k == 3);
				pending.push_back(c);
			end
		endfunction

		function void check_corner(corner_t got);
			corner_t want;
			corners_seen++;
			if (got.degenerate) degen_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected corner result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] start_x = 0, start_y = 0, start_z = 0;
	logic signed [31:0] end_x = 0, end_y = 0, end_z = 0;
	logic [30:0] line_width = 0;
	logic [31:0] line_color = 0;
	logic out_valid;
	logic out_stall = 1;
	logic [1:0] corner;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic [31:0] vert_color;
	logic signed [31:0] bound_min_x, bound_min_y, bound_max_x, bound_max_y;
	logic degenerate, last_of_run;

	quad_scoreboard sb = new();
	bit calm = 0;
	bit hold_rx = 0;
	int sent = 0;

	line_to_quad_expand_core u_top (.*);

	always #5 clk = ~clk;

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7fff_ffff - $urandom_range(0, 3);
			2: return $urandom_range(0, 255) - 128;
			3: return ($urandom_range(0, 2047) - 1024) << 16;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_segment(logic [31:0] sx, sy, sz, ex, ey, ez,
			logic [30:0] w, logic [31:0] color);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_x <= sx; start_y <= sy; start_z <= sz;
		end_x <= ex; end_y <= ey; end_z <= ez;
		line_width <= w; line_color <= color;
		do @(posedge clk); while (in_stall);
		sb.note_segment(sx, sy, sz, ex, ey, ez, w, color);
		sent++;
	endtask

	task automatic send_random();
		logic [31:0] sx, sy, sz;
		logic [30:0] w;
		sx = rand_coord(); sy = rand_coord(); sz = rand_coord();
		w = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
		case ($urandom_range(0, 9))
			0: send_segment(sx, sy, sz, sx, sy, sz, w, $urandom);
			1: send_segment(sx, sy, sz, sx + $urandom_range(0, 2) - 1,
				sy + $urandom_range(0, 2) - 1, sz, w, $urandom);
			default: send_segment(sx, sy, sz, rand_coord(), rand_coord(), rand_coord(),
				w, $urandom);
		endcase
	endtask

	// result side: random stalls, one long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_corner('{corner, pos_x, pos_y, pos_z, vert_color, bound_min_x,
					bound_min_y, bound_max_x, bound_max_y, degenerate, last_of_run});
		end
	end

	initial begin
		int n;
		@(posedge clk);
		while (1) begin
			if (hold_rx) begin
				out_stall <= 1'b1;
				n = 0;
				while (n < 300) begin
					@(posedge clk);
					n++;
				end
				hold_rx = 0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	initial begin
		int spin;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// zero length, extremes, both direction signs on each axis, width extremes
		send_segment(0, 0, 0, 0, 0, 0, 31'h7fff_ffff, 32'hffff_ffff);
		send_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 32'h1234_5678);
		send_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff, 0);
		send_segment(0, 0, 0, 32'h0001_0000, 0, 0, 31'h0001_0000, 32'haaaa_5555);
		send_segment(0, 0, 0, 0, 32'h0001_0000, 0, 31'h0002_0000, 32'h5555_aaaa);
		send_segment(0, 0, 0, 0, 0, 32'h0001_0000, 31'h0004_0000, 1);
		send_segment(0, 0, 0, -32'sh10000, -32'sh10000, 0, 31'h0003_0000, 2);
		send_segment(5, 5, 5, 6, 5, 5, 31'h1, 3);
		send_segment(5, 5, 5, 5, 4, 5, 31'h0, 4);
		send_segment(32'h7fff_0000, 32'h7fff_0000, 0, 32'h7fff_ffff, 32'h7fff_0000, 0,
			31'h7fff_ffff, 5);
		send_segment(32'h8000_0000, 32'h8000_0000, 7, 32'h8000_0000, 32'h8000_ffff, 9,
			31'h7fff_ffff, 6);
		send_segment(-3, 7, 32'h8000_0000, -3, 7, 32'h8000_0000, 31'h0, 7);
		// long output hold-off while input keeps coming
		hold_rx = 1;
		repeat (20) send_random();
		repeat (260) send_random();
		calm = 1;
		repeat (40) send_random();
		in_valid <= 1'b0;
		spin = 0;
		while (sb.pending.size() != 0 && spin < 20000) begin
			@(posedge clk);
			spin++;
		end
		repeat (100) @(posedge clk);
		$display("covered %0d segments, %0d corner results, %0d degenerate",
			sent, sb.corners_seen, sb.degen_seen);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb_line_to_quad_expand_core: done, clean");
		else
			$display("tb_line_to_quad_expand_core: done, errors");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb_line_to_quad_expand_core: done, errors");
		$finish;
	end
endmodule

### line_to_quad_expand_core.f
rtl/ltq_pkg.sv
rtl/ltq_front.sv
rtl/ltq_queue.sv
rtl/ltq_back.sv
rtl/line_to_quad_expand_core.sv
tb/tb_line_to_quad_expand_core.sv
